// File: rtl/tsa_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and defaults for the time range stream aggregator.
// Used by the top level and the testbench through scoped names; depends on nothing.
package tsa_pkg;

  localparam int TIME_W  = 64;
  localparam int VAL_W   = 32;
  localparam int AGG_W   = 52;
  localparam int CNT_W   = 21;
  localparam int SQS_W   = 84;
  localparam int OP_W    = 2;
  localparam int MODE_W  = 3;
  localparam int CIDX_W  = 2;

  localparam int MAX_POINTS_DEFAULT = 1048576;

  localparam logic [OP_W-1:0] OP_SAMPLE     = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE_FIN = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH     = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE       = 2'd3;

  localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUM    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MEAN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIN    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MAX    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LAST   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_STDDEV = 3'd7;

  localparam logic [CIDX_W-1:0] REG_AGG_MODE      = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WINDOW_ENABLE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_WINDOW_START  = 2'd2;
  localparam logic [CIDX_W-1:0] REG_WINDOW_END    = 2'd3;

endpackage

// File: rtl/time_range_stream_aggregator_core.sv
`timescale 1ns / 1ps
// Top level of the time range stream aggregator: filter, accumulators and
// the sequencer around one shared multiplier, divider and square root step.
// Depends on tsa_pkg.
//
// A sample beat is registered, then checked against the window while the shared
// 32 by 32 bit square is formed, then accumulated, before the input is ready
// again. A finish then picks the aggregate and loads the output register; for
// mean the bit-serial divider runs between the two, and for standard deviation
// two divisions, a square and the square root. The result waits in an
// output register until it is taken, and the next result stalls the input
// until that register is free.
module time_range_stream_aggregator_core #(
  parameter int MAX_POINTS = tsa_pkg::MAX_POINTS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tsa_pkg::CIDX_W-1:0]          cfg_index,
  input  logic [tsa_pkg::TIME_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [tsa_pkg::OP_W-1:0]            op,
  input  logic signed [tsa_pkg::TIME_W-1:0]   sample_time,
  input  logic signed [tsa_pkg::VAL_W-1:0]    sample_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tsa_pkg::AGG_W-1:0]    agg_value,
  output logic signed [tsa_pkg::TIME_W-1:0]   agg_time,
  output logic [tsa_pkg::CNT_W-1:0]           sample_count,
  output logic                                empty_set
);

  localparam int TW = tsa_pkg::TIME_W;
  localparam int VW = tsa_pkg::VAL_W;
  localparam int AW = tsa_pkg::AGG_W;
  localparam int CW = tsa_pkg::CNT_W;
  localparam int SW = tsa_pkg::SQS_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic [6:0] DIV_LAST = 7'(SW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_ACC, S_FIN, S_DIV_MEAN, S_SQ_MEAN, S_DIV_SQ, S_SQRT, S_OUT
  } state_t;

  state_t state;

  logic [tsa_pkg::MODE_W-1:0] agg_mode;
  logic                       window_enable;
  logic signed [TW-1:0]       window_start;
  logic signed [TW-1:0]       window_end;

  logic [tsa_pkg::OP_W-1:0] cur_op;
  logic signed [TW-1:0]     cur_time;
  logic signed [VW-1:0]     cur_value;
  logic                     pass;

  logic [CW-1:0]        accepted_count;
  logic signed [AW-1:0] running_sum;
  logic [SW-1:0]        square_sum;
  logic signed [VW-1:0] running_min;
  logic signed [VW-1:0] running_max;
  logic signed [VW-1:0] first_value;
  logic signed [TW-1:0] first_stamp;
  logic signed [VW-1:0] last_value;
  logic signed [TW-1:0] last_stamp;

  logic [VW-1:0]   mul_a;
  logic [VW-1:0]   mean_mag;
  logic [2*VW-1:0] prod;
  logic [SW-1:0]   num;
  logic [CW-1:0]   rem;
  logic [6:0]      step;
  logic [TW-1:0]   root;
  logic [TW-1:0]   root_bit;

  logic signed [AW-1:0] res_value;
  logic signed [TW-1:0] res_time;

  logic [CW+1:0] div_trial;
  logic [CW+1:0] div_diff;
  logic          div_ge;
  logic [TW-1:0] sq_trial;
  logic          sq_ge;
  logic          in_window;
  logic [AW-1:0] sum_mag;

  assign in_stall = (state != S_IDLE);

  assign mul_a = (state == S_CHECK) ?
                 (cur_value[VW-1] ? VW'(-cur_value) : VW'(cur_value)) : mean_mag;

  assign div_trial = {1'b0, rem, num[SW-1]};
  assign div_diff  = div_trial - {2'b00, accepted_count};
  assign div_ge    = !div_diff[CW+1];
  assign sq_trial  = root + root_bit;
  assign sq_ge     = (num[TW-1:0] >= sq_trial);
  assign in_window = !window_enable ||
                     ((cur_time >= window_start) && (cur_time <= window_end));
  assign sum_mag   = running_sum[AW-1] ? AW'(-running_sum) : AW'(running_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      agg_mode       <= tsa_pkg::MODE_COUNT;
      window_enable  <= 1'b0;
      window_start   <= {1'b1, {(TW-1){1'b0}}};
      window_end     <= {1'b0, {(TW-1){1'b1}}};
      out_valid      <= 1'b0;
      accepted_count <= '0;
      running_sum    <= '0;
      square_sum     <= '0;
      running_min    <= '0;
      running_max    <= '0;
      first_value    <= '0;
      first_stamp    <= '0;
      last_value     <= '0;
      last_stamp     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tsa_pkg::REG_AGG_MODE:      agg_mode <= cfg_data[tsa_pkg::MODE_W-1:0];
          tsa_pkg::REG_WINDOW_ENABLE: window_enable <= cfg_data[0];
          tsa_pkg::REG_WINDOW_START:  window_start <= cfg_data;
          tsa_pkg::REG_WINDOW_END:    window_end <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_op    <= op;
            cur_time  <= sample_time;
            cur_value <= sample_value;
            if (op == tsa_pkg::OP_NONE) begin
              state <= S_IDLE;
            end else if (op == tsa_pkg::OP_FINISH) begin
              state <= S_FIN;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          pass  <= in_window && (accepted_count < MAX_CNT);
          prod  <= mul_a * mul_a;
          state <= S_ACC;
        end
        S_ACC: begin
          if (pass) begin
            if (accepted_count == '0) begin
              running_min <= cur_value;
              running_max <= cur_value;
              first_value <= cur_value;
              first_stamp <= cur_time;
            end else begin
              if (cur_value < running_min) running_min <= cur_value;
              if (cur_value > running_max) running_max <= cur_value;
            end
            last_value     <= cur_value;
            last_stamp     <= cur_time;
            running_sum    <= running_sum + AW'(cur_value);
            square_sum     <= square_sum + SW'(prod);
            accepted_count <= accepted_count + 1'b1;
          end
          state <= (cur_op == tsa_pkg::OP_SAMPLE_FIN) ? S_FIN : S_IDLE;
        end
        S_FIN: begin
          num  <= {{(SW-AW){1'b0}}, sum_mag};
          rem  <= '0;
          step <= '0;
          if (accepted_count == '0) begin
            res_value <= '0;
            res_time  <= '0;
            state     <= S_OUT;
          end else begin
            unique case (agg_mode)
              tsa_pkg::MODE_COUNT: begin
                res_value <= AW'(accepted_count);
                res_time  <= '0;
                state     <= S_OUT;
              end
              tsa_pkg::MODE_SUM: begin
                res_value <= running_sum;
                res_time  <= '0;
                state     <= S_OUT;
              end
              tsa_pkg::MODE_MIN: begin
                res_value <= AW'(running_min);
                res_time  <= '0;
                state     <= S_OUT;
              end
              tsa_pkg::MODE_MAX: begin
                res_value <= AW'(running_max);
                res_time  <= '0;
                state     <= S_OUT;
              end
              tsa_pkg::MODE_FIRST: begin
                res_value <= AW'(first_value);
                res_time  <= first_stamp;
                state     <= S_OUT;
              end
              tsa_pkg::MODE_LAST: begin
                res_value <= AW'(last_value);
                res_time  <= last_stamp;
                state     <= S_OUT;
              end
              default: begin
                res_time <= '0;
                state    <= S_DIV_MEAN;
              end
            endcase
          end
        end
        S_DIV_MEAN: begin
          num  <= {num[SW-2:0], div_ge};
          rem  <= div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            if (agg_mode == tsa_pkg::MODE_MEAN) begin
              res_value <= running_sum[AW-1] ?
                           AW'(-{num[SW-2:0], div_ge}) : AW'({num[SW-2:0], div_ge});
              state <= S_OUT;
            end else begin
              mean_mag <= {num[VW-2:0], div_ge};
              state    <= S_SQ_MEAN;
            end
          end
        end
        S_SQ_MEAN: begin
          prod  <= mul_a * mul_a;
          num   <= square_sum;
          rem   <= '0;
          step  <= '0;
          state <= S_DIV_SQ;
        end
        S_DIV_SQ: begin
          rem  <= div_ge ? div_diff[CW-1:0] : div_trial[CW-1:0];
          step <= step + 1'b1;
          if (step == DIV_LAST) begin
            if ({num[TW-2:0], div_ge} > prod) begin
              num <= SW'({num[TW-2:0], div_ge} - prod);
            end else begin
              num <= '0;
            end
            root     <= '0;
            root_bit <= {2'b01, {(TW-2){1'b0}}};
            state    <= S_SQRT;
          end else begin
            num <= {num[SW-2:0], div_ge};
          end
        end
        S_SQRT: begin
          if (root_bit == '0) begin
            res_value <= AW'(root);
            state     <= S_OUT;
          end else begin
            if (sq_ge) begin
              num  <= SW'(num[TW-1:0] - sq_trial);
              root <= (root >> 1) + root_bit;
            end else begin
              root <= root >> 1;
            end
            root_bit <= root_bit >> 2;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            agg_value      <= res_value;
            agg_time       <= res_time;
            sample_count   <= accepted_count;
            empty_set      <= (accepted_count == '0);
            accepted_count <= '0;
            running_sum    <= '0;
            square_sum     <= '0;
            running_min    <= '0;
            running_max    <= '0;
            first_value    <= '0;
            first_stamp    <= '0;
            last_value     <= '0;
            last_stamp     <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    accepted_count <= MAX_CNT)
    else $error("accepted count exceeds the point limit");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && empty_set |-> agg_value == '0 && agg_time == '0 && sample_count == '0)
    else $error("empty result carries data");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_MEAN || state == S_DIV_SQ) |-> accepted_count != '0)
    else $error("divider running with zero count");

  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && (!out_valid || !out_stall) |=> accepted_count == '0 && out_valid)
    else $error("aggregate not cleared after a result");

endmodule

// File: tb/tb_time_range_stream_aggregator_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for time_range_stream_aggregator_core: a directed table, a window
// test, then random sample sets, each finish beat checked against an in-bench aggregate
// predictor. Depends on tsa_pkg and the core RTL.
module tb_time_range_stream_aggregator_core;

  localparam int OP_W   = tsa_pkg::OP_W;
  localparam int TIME_W = tsa_pkg::TIME_W;
  localparam int VAL_W  = tsa_pkg::VAL_W;
  localparam int AGG_W  = tsa_pkg::AGG_W;
  localparam int CNT_W  = tsa_pkg::CNT_W;
  localparam int SQS_W  = tsa_pkg::SQS_W;
  localparam int MODE_W = tsa_pkg::MODE_W;
  localparam int CIDX_W = tsa_pkg::CIDX_W;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic signed [TIME_W-1:0] t;
    logic signed [VAL_W-1:0] v;
    logic has_exp;
    logic signed [AGG_W-1:0] e_val;
    logic [CNT_W-1:0] e_cnt;
    logic e_empty;
  } stim_row_t;

  typedef struct packed {
    logic signed [AGG_W-1:0] val;
    logic signed [TIME_W-1:0] tim;
    logic [CNT_W-1:0] cnt;
    logic empty;
  } agg_expect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] op = tsa_pkg::OP_SAMPLE;
  logic signed [TIME_W-1:0] sample_time = '0;
  logic signed [VAL_W-1:0] sample_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [AGG_W-1:0] agg_value;
  logic signed [TIME_W-1:0] agg_time;
  logic [CNT_W-1:0] sample_count;
  logic empty_set;

  time_range_stream_aggregator_core dut (.*);

  always #5 clk = ~clk;

  // Predictor copy of registers and accumulators.
  logic [MODE_W-1:0] p_mode;
  logic p_win_en;
  logic signed [63:0] p_win_lo, p_win_hi;
  logic [CNT_W-1:0] p_cnt;
  logic signed [63:0] p_sum;
  logic [SQS_W-1:0] p_sqs;
  logic signed [31:0] p_min, p_max, p_first_v, p_last_v;
  logic signed [63:0] p_first_t, p_last_t;

  agg_expect_t expected_aggs[$];
  int errors = 0;
  int long_hold = 0;
  int hold_req = 0;
  int hold_served = 0;

  function automatic void clear_aggregate();
    p_cnt = '0; p_sum = '0; p_sqs = '0; p_min = '0; p_max = '0;
    p_first_v = '0; p_last_v = '0; p_first_t = '0; p_last_t = '0;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void aggregate_beat(logic [OP_W-1:0] o, logic signed [63:0] t,
                                         logic signed [31:0] v);
    agg_expect_t r;
    logic signed [63:0] mean, am;
    logic [SQS_W-1:0] ex2;
    logic [63:0] m2;
    logic [63:0] vmag;
    if (o == tsa_pkg::OP_SAMPLE || o == tsa_pkg::OP_SAMPLE_FIN) begin
      if (!(p_win_en && (t < p_win_lo || t > p_win_hi)) &&
          p_cnt < tsa_pkg::MAX_POINTS_DEFAULT) begin
        if (p_cnt == 0) begin
          p_min = v; p_max = v; p_first_v = v; p_first_t = t;
        end else begin
          if (v < p_min) p_min = v;
          if (v > p_max) p_max = v;
        end
        p_last_v = v; p_last_t = t;
        p_sum = p_sum + 64'(v);
        vmag = (v < 0) ? -64'(v) : 64'(v);
        p_sqs = p_sqs + SQS_W'(vmag * vmag);
        p_cnt = p_cnt + 1'b1;
      end
    end
    if (o == tsa_pkg::OP_SAMPLE_FIN || o == tsa_pkg::OP_FINISH) begin
      r = '0;
      r.cnt = p_cnt;
      r.empty = (p_cnt == 0);
      if (p_cnt != 0) begin
        mean = p_sum / $signed({43'd0, p_cnt});
        case (p_mode)
          tsa_pkg::MODE_COUNT: r.val = AGG_W'(p_cnt);
          tsa_pkg::MODE_SUM: r.val = AGG_W'(p_sum);
          tsa_pkg::MODE_MEAN: r.val = AGG_W'(mean);
          tsa_pkg::MODE_MIN: r.val = AGG_W'(p_min);
          tsa_pkg::MODE_MAX: r.val = AGG_W'(p_max);
          tsa_pkg::MODE_FIRST: begin r.val = AGG_W'(p_first_v); r.tim = p_first_t; end
          tsa_pkg::MODE_LAST: begin r.val = AGG_W'(p_last_v); r.tim = p_last_t; end
          default: begin
            ex2 = p_sqs / SQS_W'(p_cnt);
            am = (mean < 0) ? -mean : mean;
            m2 = am * am;
            r.val = AGG_W'(isqrt((ex2[63:0] > m2) ? ex2[63:0] - m2 : 64'd0));
          end
        endcase
      end
      expected_aggs.push_back(r);
      clear_aggregate();
    end
  endfunction

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [63:0] d);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      tsa_pkg::REG_AGG_MODE: p_mode = d[MODE_W-1:0];
      tsa_pkg::REG_WINDOW_ENABLE: p_win_en = d[0];
      tsa_pkg::REG_WINDOW_START: p_win_lo = d;
      default: p_win_hi = d;
    endcase
  endtask

  task automatic drain();
    while (expected_aggs.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic send_beat(logic [OP_W-1:0] o, logic signed [63:0] t, logic signed [31:0] v);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; op <= o; sample_time <= t; sample_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    aggregate_beat(o, t, v);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 2000) - 1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_stamp();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return 64'sd1000 * $urandom_range(0, 200) - 64'sd100000;
      default: return 64'($urandom_range(0, 4000)) - 64'sd2000;
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{tsa_pkg::OP_FINISH, 64'sd0, 32'sd0, 1'b1, 52'sd0, 21'd0, 1'b1},
    '{tsa_pkg::OP_SAMPLE, 64'sd5, 32'sh7fffffff, 1'b0, 52'sd0, 21'd0, 1'b0},
    '{tsa_pkg::OP_SAMPLE, 64'sd6, 32'sh80000000, 1'b0, 52'sd0, 21'd0, 1'b0},
    '{tsa_pkg::OP_SAMPLE_FIN, 64'sd7, 32'sd65536, 1'b1, 52'sd3, 21'd3, 1'b0},
    '{tsa_pkg::OP_NONE, 64'sd8, 32'sd1, 1'b0, 52'sd0, 21'd0, 1'b0},
    '{tsa_pkg::OP_SAMPLE_FIN, -64'sd1, -32'sd1, 1'b1, 52'sd1, 21'd1, 1'b0},
    '{tsa_pkg::OP_SAMPLE, 64'h7fffffffffffffff, 32'sd3, 1'b0, 52'sd0, 21'd0, 1'b0},
    '{tsa_pkg::OP_SAMPLE, 64'h8000000000000000, 32'sd0, 1'b0, 52'sd0, 21'd0, 1'b0},
    '{tsa_pkg::OP_FINISH, 64'sd0, 32'sd0, 1'b1, 52'sd2, 21'd2, 1'b0}
  };

  // Receiver: checks results; random stalls, plus one long hold-off requested by the sender.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (expected_aggs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat val=%0d", agg_value);
      end else begin
        agg_expect_t e;
        e = expected_aggs.pop_front();
        if (e !== {agg_value, agg_time, sample_count, empty_set}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp val=%0d time=%0d cnt=%0d empty=%0b got %0d %0d %0d %0b",
                     e.val, e.tim, e.cnt, e.empty, agg_value, agg_time, sample_count,
                     empty_set);
        end
      end
    end
    if (hold_req != hold_served) begin
      long_hold <= 400;
      hold_served <= hold_req;
      out_stall <= 1'b1;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int n;
    int phase;
    p_mode = tsa_pkg::MODE_COUNT; p_win_en = 1'b0;
    p_win_lo = 64'h8000000000000000; p_win_hi = 64'h7fffffffffffffff;
    clear_aggregate();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (i == 5) begin
        in_valid <= 1'b0;
        drain();
        write_reg(tsa_pkg::REG_AGG_MODE, tsa_pkg::MODE_COUNT);
      end
      send_beat(directed[i].op, directed[i].t, directed[i].v);
      if (directed[i].has_exp && expected_aggs.size() != 0) begin
        agg_expect_t e;
        e = expected_aggs[$];
        if (e.val !== directed[i].e_val || e.cnt !== directed[i].e_cnt ||
            e.empty !== directed[i].e_empty) begin
          errors++;
          if (errors <= 10) $display("directed row %0d disagrees with predictor", i);
        end
      end
    end
    in_valid <= 1'b0;
    drain();
    // Window start after end while filtering, then the window extremes.
    write_reg(tsa_pkg::REG_WINDOW_ENABLE, 64'd1);
    write_reg(tsa_pkg::REG_WINDOW_START, 64'sd10);
    write_reg(tsa_pkg::REG_WINDOW_END, 64'sd5);
    send_beat(tsa_pkg::OP_SAMPLE, 64'sd7, 32'sd9);
    send_beat(tsa_pkg::OP_SAMPLE_FIN, 64'sd10, 32'sd9);
    in_valid <= 1'b0;
    drain();
    write_reg(tsa_pkg::REG_WINDOW_START, 64'h8000000000000000);
    write_reg(tsa_pkg::REG_WINDOW_END, 64'h7fffffffffffffff);
    n = 0;
    for (phase = 0; phase < 16; phase++) begin
      in_valid <= 1'b0;
      drain();
      write_reg(tsa_pkg::REG_AGG_MODE, MODE_W'(phase % 8));
      write_reg(tsa_pkg::REG_WINDOW_ENABLE, 64'($urandom_range(0, 1)));
      if (phase % 4 == 3) begin
        write_reg(tsa_pkg::REG_WINDOW_START, 64'h8000000000000000);
        write_reg(tsa_pkg::REG_WINDOW_END, 64'h7fffffffffffffff);
      end else begin
        write_reg(tsa_pkg::REG_WINDOW_START, -64'sd1000 - $urandom_range(0, 500));
        write_reg(tsa_pkg::REG_WINDOW_END, 64'sd1000 + $urandom_range(0, 500));
      end
      if (phase == 5) hold_req = hold_req + 1;
      repeat (60) begin
        logic [OP_W-1:0] o;
        case ($urandom_range(0, 19))
          0, 1: o = tsa_pkg::OP_SAMPLE_FIN;
          2: o = tsa_pkg::OP_FINISH;
          3: o = tsa_pkg::OP_NONE;
          default: o = tsa_pkg::OP_SAMPLE;
        endcase
        send_beat(o, rand_stamp(), rand_value());
        n++;
      end
      send_beat(tsa_pkg::OP_FINISH, '0, '0);
    end
    in_valid <= 1'b0;
    drain();
    if (errors == 0) begin
      $display("time_range_stream_aggregator_core test passed");
    end else begin
      $display("time_range_stream_aggregator_core test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("time_range_stream_aggregator_core test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tsa_pkg.sv
rtl/time_range_stream_aggregator_core.sv
tb/tb_time_range_stream_aggregator_core.sv
